@@ rtl/cbm_pkg.sv @@
// Shared constants, codes and types of the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned PAGE_W    = 8;
  localparam int unsigned NT_PAGE_W = 9;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned DIV_W     = CFG_W + 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_UNITS = 2'd1;

  // Mapper register addresses
  localparam logic [ADDR_W-1:0] ADDR_CHR0  = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_CHR1  = 16'h9000;
  localparam logic [ADDR_W-1:0] ADDR_CHR2  = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_CHR3  = 16'hB000;
  localparam logic [ADDR_W-1:0] ADDR_NT0   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_NT1   = 16'hD000;
  localparam logic [ADDR_W-1:0] ADDR_CTRL  = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_PRG   = 16'hF000;

  // Control byte fields and nametable page offset
  localparam int unsigned CTRL_FLAG_BIT = 4;
  localparam logic [NT_PAGE_W-1:0] NT_PAGE_BASE = 9'h080;

  // Mirroring modes
  localparam logic [MODE_W-1:0] MIRROR_ALT    = 2'd0;
  localparam logic [MODE_W-1:0] MIRROR_PAIR   = 2'd1;
  localparam logic [MODE_W-1:0] MIRROR_ONE_S0 = 2'd2;
  localparam logic [MODE_W-1:0] MIRROR_ONE_S1 = 2'd3;

  localparam logic [CFG_W-1:0] UNITS_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ rtl/cbm_in_if.sv @@
// Input channel: one CPU write to the mapper.
interface cbm_in_if;
  import cbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, output address, output data, input ready);
  modport sink   (input valid, input address, input data, output ready);
endinterface

@@ rtl/cbm_out_if.sv @@
// Result channel: the full set of page mappings after one write.
interface cbm_out_if;
  import cbm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAGE_W-1:0]    chr_page_a;
  logic [PAGE_W-1:0]    chr_page_b;
  logic [PAGE_W-1:0]    chr_page_c;
  logic [PAGE_W-1:0]    chr_page_d;
  logic [NT_PAGE_W-1:0] nt_page_0;
  logic [NT_PAGE_W-1:0] nt_page_1;
  logic [NT_PAGE_W-1:0] nt_page_2;
  logic [NT_PAGE_W-1:0] nt_page_3;
  logic                 nt_from_rom;
  logic [MODE_W-1:0]    mirror_mode;
  logic [PAGE_W-1:0]    prg_page;

  modport source (
    output valid, input ready,
    output chr_page_a, output chr_page_b, output chr_page_c, output chr_page_d,
    output nt_page_0, output nt_page_1, output nt_page_2, output nt_page_3,
    output nt_from_rom, output mirror_mode, output prg_page
  );
  modport sink (
    input valid, output ready,
    input chr_page_a, input chr_page_b, input chr_page_c, input chr_page_d,
    input nt_page_0, input nt_page_1, input nt_page_2, input nt_page_3,
    input nt_from_rom, input mirror_mode, input prg_page
  );
endinterface

@@ rtl/cartridge_bank_mapper.sv @@
// Cartridge bank mapper top level: register decode, serial remainder unit and result register.
//
// Each transfer on the input channel is one CPU write. Writes to exactly 0x8000, 0x9000,
// 0xA000 or 0xB000 set a 2KB pattern bank, 0xF000 sets the switchable program bank; these
// take the data byte modulo the ROM size (pattern: four times chr_rom_units, program:
// prg_rom_units, no modulo when the divisor is zero) and double it into an even page.
// 0xC000/0xD000 load the nametable source bytes, 0xE000 loads the ROM nametable flag
// (bit 4) and mirroring mode (bits 1:0); any other address changes nothing. Every write
// produces one result transfer carrying all page mappings. A bank write holds the block for
// the accepting cycle, eight steps of the bit-serial restoring remainder unit and one
// commit; every other write goes from the accepting cycle straight to the commit. The input
// is not ready while a write is being processed. The result sits in an output register, so
// the next write is accepted while a result still waits; its commit then holds until that
// result is taken, so a result-side stall lengthens the busy time.
// Configuration writes are taken at any edge with cfg_we high; indexes beyond 1 are ignored.
module cartridge_bank_mapper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbm_pkg::CFG_W-1:0]     cfg_data,
  cbm_in_if.sink                        in_ch,
  cbm_out_if.source                     out_ch
);
  import cbm_pkg::*;

  // Configuration
  logic [CFG_W-1:0] chr_units_r;
  logic [CFG_W-1:0] prg_units_r;

  // Mapper state
  logic [PAGE_W-1:0] chr_bank_r [4];
  logic [PAGE_W-1:0] chr_bank_nxt [4];
  logic [DATA_W-1:0] nt_src_r [2];
  logic [DATA_W-1:0] nt_src_nxt [2];
  logic              nt_flag_r, nt_flag_nxt;
  logic [MODE_W-1:0] mirror_r, mirror_nxt;
  logic [PAGE_W-1:0] prg_bank_r, prg_bank_nxt;

  // Sequencer and remainder unit
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [2:0]        cnt_r, cnt_nxt;

  logic [DATA_W:0]   rem_sh;
  logic              rem_ge;
  logic [PAGE_W-1:0] page_val;
  logic              is_chr_addr;
  logic              commit;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]    out_chr_r [4];
  logic [NT_PAGE_W-1:0] out_nt_r [4];
  logic [NT_PAGE_W-1:0] nt_pg_nxt [4];
  logic [NT_PAGE_W-1:0] s0_pg, s1_pg;
  logic                 out_flag_r;
  logic [MODE_W-1:0]    out_mode_r;
  logic [PAGE_W-1:0]    out_prg_r;

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chr_page_a  = out_chr_r[0];
  assign out_ch.chr_page_b  = out_chr_r[1];
  assign out_ch.chr_page_c  = out_chr_r[2];
  assign out_ch.chr_page_d  = out_chr_r[3];
  assign out_ch.nt_page_0   = out_nt_r[0];
  assign out_ch.nt_page_1   = out_nt_r[1];
  assign out_ch.nt_page_2   = out_nt_r[2];
  assign out_ch.nt_page_3   = out_nt_r[3];
  assign out_ch.nt_from_rom = out_flag_r;
  assign out_ch.mirror_mode = out_mode_r;
  assign out_ch.prg_page    = out_prg_r;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  // The remainder never exceeds the dividend, so eight bits hold it.
  assign rem_sh   = {rem_r, shift_r[DATA_W-1]};
  assign rem_ge   = ({1'b0, rem_sh} >= div_r);
  assign page_val = {rem_r[PAGE_W-2:0], 1'b0};

  assign is_chr_addr = (in_ch.address == ADDR_CHR0) || (in_ch.address == ADDR_CHR1) ||
                       (in_ch.address == ADDR_CHR2) || (in_ch.address == ADDR_CHR3);

  // Commit once the result register is free or being emptied
  assign commit = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_units_r <= UNITS_RESET;
      prg_units_r <= UNITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHR_UNITS: chr_units_r <= cfg_data;
        CFG_PRG_UNITS: prg_units_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chr_bank_r  <= '{default: '0};
      nt_src_r    <= '{default: '0};
      nt_flag_r   <= 1'b0;
      mirror_r    <= '0;
      prg_bank_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chr_bank_r  <= chr_bank_nxt;
      nt_src_r    <= nt_src_nxt;
      nt_flag_r   <= nt_flag_nxt;
      mirror_r    <= mirror_nxt;
      prg_bank_r  <= prg_bank_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    data_r  <= data_nxt;
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    if (commit) begin
      out_chr_r  <= chr_bank_nxt;
      out_nt_r   <= nt_pg_nxt;
      out_flag_r <= nt_flag_nxt;
      out_mode_r <= mirror_nxt;
      out_prg_r  <= prg_bank_nxt;
    end
  end

  // Next state, remainder steps and register decode
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    shift_nxt     = shift_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    chr_bank_nxt  = chr_bank_r;
    nt_src_nxt    = nt_src_r;
    nt_flag_nxt   = nt_flag_r;
    mirror_nxt    = mirror_r;
    prg_bank_nxt  = prg_bank_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          addr_nxt  = in_ch.address;
          data_nxt  = in_ch.data;
          shift_nxt = in_ch.data;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          div_nxt   = (in_ch.address == ADDR_PRG) ? {2'b00, prg_units_r}
                                                  : {chr_units_r, 2'b00};
          // Only bank writes need the remainder unit
          state_nxt = (is_chr_addr || (in_ch.address == ADDR_PRG)) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        rem_nxt   = rem_ge ? DATA_W'({1'b0, rem_sh} - div_r) : rem_sh[DATA_W-1:0];
        shift_nxt = {shift_r[DATA_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          unique case (addr_r)
            ADDR_CHR0: chr_bank_nxt[0] = page_val;
            ADDR_CHR1: chr_bank_nxt[1] = page_val;
            ADDR_CHR2: chr_bank_nxt[2] = page_val;
            ADDR_CHR3: chr_bank_nxt[3] = page_val;
            ADDR_NT0:  nt_src_nxt[0]   = data_r;
            ADDR_NT1:  nt_src_nxt[1]   = data_r;
            ADDR_CTRL: begin
              nt_flag_nxt = data_r[CTRL_FLAG_BIT];
              mirror_nxt  = data_r[MODE_W-1:0];
            end
            ADDR_PRG:  prg_bank_nxt    = page_val;
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Nametable pages from the updated source bytes and mode
  always_comb begin
    s0_pg = NT_PAGE_BASE + {1'b0, nt_src_nxt[0]};
    s1_pg = NT_PAGE_BASE + {1'b0, nt_src_nxt[1]};
    unique case (mirror_nxt)
      MIRROR_ALT:    nt_pg_nxt = '{s0_pg, s1_pg, s0_pg, s1_pg};
      MIRROR_PAIR:   nt_pg_nxt = '{s0_pg, s0_pg, s1_pg, s1_pg};
      MIRROR_ONE_S0: nt_pg_nxt = '{s0_pg, s0_pg, s0_pg, s0_pg};
      MIRROR_ONE_S1: nt_pg_nxt = '{s1_pg, s1_pg, s1_pg, s1_pg};
      default:       nt_pg_nxt = '{s1_pg, s1_pg, s1_pg, s1_pg};
    endcase
  end

  // An accepted write keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE))
    else $error("input still ready after a write was accepted");

  // The running remainder stays below a non-zero divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && (div_r != '0)) |-> ({2'b00, rem_r} < div_r))
    else $error("remainder unit out of range");

  // A pending commit holds while the previous result is not taken
  a_commit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_valid_r && !out_ch.ready) |=>
      ((state_r == ST_DONE) && out_valid_r))
    else $error("commit overtook an unsent result");

  // Bank pages are always even
  a_pages_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_prg_r[0] && !out_chr_r[0][0] && !out_chr_r[1][0] &&
                     !out_chr_r[2][0] && !out_chr_r[3][0]))
    else $error("odd bank page reported");

endmodule
